// File: rtl/yin_pitch_detector_assert.svh
// Assertion macros for the YIN pitch detector.
// Included by the top level; the including module must provide clk and rst_n.
`ifndef YIN_PITCH_DETECTOR_ASSERT_SVH
`define YIN_PITCH_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YIN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define YIN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/yin_pkg.sv
// Shared constants, types and helper functions for the YIN pitch detector.
// No dependencies; used by yin_div, yin_pitch_detector and the testbench.
`default_nettype none

package yin_pkg;

    localparam int WINDOW_DEPTH_DEF = 2048;
    localparam int LAG_DEPTH_DEF    = 512;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 16;
    localparam int SUM_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int FREQ_W     = 24;
    localparam int BASE_SHIFT = 8;

    localparam logic [CFG_W-1:0]  SAMPLE_RATE_RESET = 16'd48000;
    localparam logic [CFG_W-1:0]  THRESHOLD_RESET   = 16'd9830;
    localparam logic [SUM_W-1:0]  ONE_Q16           = 48'd65536;
    localparam logic [FREQ_W-1:0] FREQ_MAX          = 24'hFFFFFF;

    typedef enum logic [0:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_THRESHOLD   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // floor(x / 100) by reciprocal multiply with a single correction step.
    function automatic logic [9:0] div_by_min_freq(input logic [15:0] x);
        logic [28:0] prod;
        logic [9:0]  q;
        logic [16:0] back;
        prod = {13'd0, x} * 29'd5243;
        q    = prod[28:19];
        back = {7'd0, q} * 17'd100;
        if (back > {1'b0, x})
        begin
            q = q - 10'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/yin_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on yin_pkg for the status struct.
`default_nettype none

module yin_div
    import yin_pkg::*;
#(
    parameter int DVD_W = 75,
    parameter int DVS_W = 59
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_stat_t             stat,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign stat     = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire

// File: rtl/yin_pitch_detector.sv
// Input: samples are taken one per cycle while collecting; after the last item the result
// follows once the multiply-accumulate has summed every lag and the serial divider has
// normalized each lag scanned and worked out the frequency.
// Throughput: one window at a time; no input is taken while a window is analyzed.
// Reset: asynchronous active-low reset clears the control state and loads the register defaults;
// the sample and difference memories are not cleared and need no clearing pass.
`default_nettype none
`include "yin_pitch_detector_assert.svh"

// Top level of the YIN pitch detector: sample memory, difference memory, analysis sequencer.
// Depends on yin_pkg, yin_div and the assertion header.
module yin_pitch_detector
    import yin_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int LAG_DEPTH    = LAG_DEPTH_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Input stream. s_tdata: [15:0] sample. s_tlast: last sample of the window.
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [SAMPLE_W-1:0] s_tdata,
    input  wire logic                s_tlast,
    // Result stream. m_tdata: [23:0] frequency_q8. m_tuser: [0] found.
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [FREQ_W-1:0]        m_tdata,
    output logic                     m_tuser,
    // Configuration writes: index 0 is the sample rate, index 1 the threshold.
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int LAG_W  = $clog2(LAG_DEPTH);
    localparam int LAGC_W = $clog2(LAG_DEPTH + 1);
    localparam int IX_W   = CNT_W + LAGC_W;
    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int PROD_W = SUM_W + LAG_W;
    localparam int DVD_W  = PROD_W + FRAC_W;
    localparam int DVS_W  = PROD_W;
    // Normalized values never exceed tau * 1.0, so they fit in NV_W bits.
    localparam int NV_W   = LAG_W + FRAC_W;
    localparam int DIV_W  = NV_W + 2;
    localparam int DD_W   = NV_W + 1;
    localparam int MUL_W  = DIV_W + LAG_W + 2;
    localparam int DEN_W  = MUL_W + 1;
    localparam int NUM_W  = DIV_W + 1 + FREQ_W;

    typedef enum logic [4:0] {
        S_COLLECT, S_START, S_DIFF, S_NRD, S_NADD, S_NDIV, S_NWAIT,
        S_RRD, S_RCMP, S_DRD, S_DCMP, S_IRD, S_IGET, S_IMUL, S_ICHK,
        S_FWAIT, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CFG_W-1:0]    sr_reg, sr_next;
    logic [CFG_W-1:0]    thr_reg, thr_next;
    logic [LAGC_W-1:0]   max_lag_reg, max_lag_next;
    logic                v1_reg, v1_next;
    logic                v2_reg, v2_next;
    logic                m_valid_reg, m_valid_next;
    logic [FREQ_W-1:0]   m_freq_reg, m_freq_next;
    logic                m_found_reg, m_found_next;

    logic [LAGC_W-1:0]   tau_reg, tau_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [PROD_W-1:0]   running_reg, running_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [LAG_W-1:0]    best_reg, best_next;
    logic [NV_W-1:0]     cur_reg, cur_next;
    logic [NV_W-1:0]     s2_reg, s2_next;
    logic signed [DIV_W-1:0] div_reg, div_next;
    logic signed [DD_W-1:0]  dd_reg, dd_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic signed [DEN_W-1:0] den_reg, den_next;
    logic [FREQ_W-1:0]   res_freq_reg, res_freq_next;
    logic                res_found_reg, res_found_next;

    // Sample memory: one write port, two registered read ports.
    logic [SAMPLE_W-1:0] smem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] sa_reg, sb_reg;
    logic                smem_we;
    logic [ADDR_W-1:0]   ra, rb;

    // Difference memory: one write port, one registered read port.
    logic [SUM_W-1:0]    dmem [LAG_DEPTH];
    logic [SUM_W-1:0]    drd_reg;
    logic                dmem_we;
    logic [LAG_W-1:0]    dwaddr, draddr;
    logic [SUM_W-1:0]    dwdata;

    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DVS_W-1:0]    div_dvs;
    div_stat_t           div_stat;
    logic [DVD_W-1:0]    div_q;

    logic                in_acc, out_acc, issue;
    logic [IX_W-1:0]     ix;
    logic [15:0]         ml_raw;
    logic signed [SAMPLE_W:0]   delta;
    logic signed [SQ_W+1:0]     sq_full;
    logic [NV_W-1:0]     rd_nv;
    logic [DIV_W-1:0]    abs_div;
    logic signed [MUL_W-1:0] den_mul;
    logic [DEN_W-1:0]    abs_den;
    logic [FREQ_W-1:0]   base;
    logic [FREQ_W-1:0]   q_sat;
    logic                tau_last;

    yin_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (smem_we)
        begin
            smem[count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        sa_reg <= smem[ra];
        sb_reg <= smem[rb];
    end

    always_ff @(posedge clk)
    begin
        if (dmem_we)
        begin
            dmem[dwaddr] <= dwdata;
        end
        drd_reg <= dmem[draddr];
    end

    assign s_tready  = (state_reg == S_COLLECT);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_freq_reg;
    assign m_tuser   = m_found_reg;

    always_comb
    begin
        in_acc   = s_tvalid && s_tready;
        out_acc  = m_valid_reg && m_tready;
        smem_we  = in_acc && (count_reg < CNT_W'(WINDOW_DEPTH));

        ix    = IX_W'(i_reg) + IX_W'(tau_reg);
        issue = (state_reg == S_DIFF) && (ix < IX_W'(count_reg));
        ra    = i_reg[ADDR_W-1:0];
        rb    = ix[ADDR_W-1:0];

        // Squared difference and accumulate stages of the lag sum.
        delta   = $signed({sa_reg[SAMPLE_W-1], sa_reg}) - $signed({sb_reg[SAMPLE_W-1], sb_reg});
        sq_full = delta * delta;

        ml_raw = {6'd0, div_by_min_freq(sr_reg)};
        if (ml_raw > 16'(LAG_DEPTH))
        begin
            ml_raw = 16'(LAG_DEPTH);
        end

        rd_nv    = drd_reg[NV_W-1:0];
        abs_div  = div_reg[DIV_W-1] ? DIV_W'(-div_reg) : DIV_W'(div_reg);
        den_mul  = $signed({div_reg, 1'b0}) * $signed({1'b0, best_reg});
        abs_den  = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
        base     = {sr_reg, 8'd0};
        q_sat    = (|div_q[DVD_W-1:FREQ_W]) ? FREQ_MAX : div_q[FREQ_W-1:0];
        tau_last = (tau_reg + LAGC_W'(1)) == max_lag_reg;

        state_next     = state_reg;
        count_next     = count_reg;
        sr_next        = sr_reg;
        thr_next       = thr_reg;
        max_lag_next   = LAGC_W'(ml_raw);
        v1_next        = issue;
        v2_next        = v1_reg;
        m_valid_next   = out_acc ? 1'b0 : m_valid_reg;
        m_freq_next    = m_freq_reg;
        m_found_next   = m_found_reg;
        tau_next       = tau_reg;
        i_next         = issue ? i_reg + CNT_W'(1) : i_reg;
        acc_next       = v2_reg ? acc_reg + SUM_W'(sq_reg) : acc_reg;
        sq_next        = sq_full[SQ_W-1:0];
        running_next   = running_reg;
        prod_next      = prod_reg;
        best_next      = best_reg;
        cur_next       = cur_reg;
        s2_next        = s2_reg;
        div_next       = div_reg;
        dd_next        = dd_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        res_freq_next  = res_freq_reg;
        res_found_next = res_found_reg;
        dmem_we        = 1'b0;
        dwaddr         = tau_reg[LAG_W-1:0];
        dwdata         = acc_reg;
        draddr         = tau_reg[LAG_W-1:0];
        div_start      = 1'b0;
        div_dvd        = {prod_reg, {FRAC_W{1'b0}}};
        div_dvs        = running_reg;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SAMPLE_RATE: sr_next  = cfg_data;
                CFG_THRESHOLD:   thr_next = cfg_data;
                default:         sr_next  = sr_reg;
            endcase
        end

        case (state_reg)
            S_COLLECT:
            begin
                if (in_acc)
                begin
                    if (smem_we)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (max_lag_reg < LAGC_W'(2))
                begin
                    res_freq_next  = '0;
                    res_found_next = 1'b0;
                    state_next     = S_DONE;
                end
                else
                begin
                    dmem_we    = 1'b1;
                    dwaddr     = '0;
                    dwdata     = ONE_Q16;
                    tau_next   = LAGC_W'(1);
                    i_next     = '0;
                    acc_next   = '0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // A lag is finished once no product is issued or in flight.
                if (!issue && !v1_reg && !v2_reg)
                begin
                    dmem_we  = 1'b1;
                    i_next   = '0;
                    acc_next = '0;
                    if (tau_last)
                    begin
                        tau_next     = LAGC_W'(1);
                        running_next = '0;
                        state_next   = S_NRD;
                    end
                    else
                    begin
                        tau_next = tau_reg + LAGC_W'(1);
                    end
                end
            end
            S_NRD:
            begin
                state_next = S_NADD;
            end
            S_NADD:
            begin
                running_next = running_reg + PROD_W'(drd_reg);
                prod_next    = PROD_W'(drd_reg) * PROD_W'(tau_reg[LAG_W-1:0]);
                state_next   = S_NDIV;
            end
            S_NDIV:
            begin
                // A zero running sum leaves the raw difference, itself zero, in place.
                if (running_reg == '0)
                begin
                    tau_next   = tau_last ? LAGC_W'(1) : tau_reg + LAGC_W'(1);
                    state_next = tau_last ? S_RRD : S_NRD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_NWAIT;
                end
            end
            S_NWAIT:
            begin
                if (div_stat.done)
                begin
                    dmem_we    = 1'b1;
                    dwdata     = div_q[SUM_W-1:0];
                    tau_next   = tau_last ? LAGC_W'(1) : tau_reg + LAGC_W'(1);
                    state_next = tau_last ? S_RRD : S_NRD;
                end
            end
            S_RRD:
            begin
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (drd_reg < SUM_W'(thr_reg))
                begin
                    best_next  = tau_reg[LAG_W-1:0];
                    cur_next   = rd_nv;
                    state_next = S_DRD;
                end
                else if (tau_last)
                begin
                    res_freq_next  = '0;
                    res_found_next = 1'b0;
                    state_next     = S_DONE;
                end
                else
                begin
                    tau_next   = tau_reg + LAGC_W'(1);
                    state_next = S_RRD;
                end
            end
            S_DRD:
            begin
                draddr = best_reg + LAG_W'(1);
                if ((LAGC_W'(best_reg) + LAGC_W'(1)) < max_lag_reg)
                begin
                    state_next = S_DCMP;
                end
                else
                begin
                    // Minimum at the top lag: no interpolation.
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(base);
                    div_dvs    = DVS_W'(best_reg);
                    state_next = S_FWAIT;
                end
            end
            S_DCMP:
            begin
                if (rd_nv < cur_reg)
                begin
                    cur_next   = rd_nv;
                    best_next  = best_reg + LAG_W'(1);
                    state_next = S_DRD;
                end
                else
                begin
                    s2_next    = rd_nv;
                    state_next = S_IRD;
                end
            end
            S_IRD:
            begin
                draddr     = best_reg - LAG_W'(1);
                state_next = S_IGET;
            end
            S_IGET:
            begin
                div_next = $signed({1'b0, cur_reg, 1'b0}) - $signed({2'b00, s2_reg})
                         - $signed({2'b00, rd_nv});
                dd_next  = $signed({1'b0, s2_reg}) - $signed({1'b0, rd_nv});
                state_next = S_IMUL;
            end
            S_IMUL:
            begin
                if (div_reg == '0)
                begin
                    // Flat parabola: fall back to the integer lag.
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(base);
                    div_dvs    = DVS_W'(best_reg);
                    state_next = S_FWAIT;
                end
                else
                begin
                    num_next   = NUM_W'({abs_div, 1'b0}) * NUM_W'(base);
                    den_next   = {den_mul[MUL_W-1], den_mul}
                               + {{(DEN_W-DD_W){dd_reg[DD_W-1]}}, dd_reg};
                    state_next = S_ICHK;
                end
            end
            S_ICHK:
            begin
                if (den_reg == '0)
                begin
                    res_freq_next  = FREQ_MAX;
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
                else if (den_reg[DEN_W-1] != div_reg[DIV_W-1])
                begin
                    // Refined lag is negative.
                    res_freq_next  = '0;
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(num_reg);
                    div_dvs    = DVS_W'(abs_den);
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                if (div_stat.done)
                begin
                    res_freq_next  = q_sat;
                    res_found_next = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_freq_next  = res_freq_reg;
                    m_found_next = res_found_reg;
                    count_next   = '0;
                    state_next   = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_COLLECT;
            count_reg   <= '0;
            sr_reg      <= SAMPLE_RATE_RESET;
            thr_reg     <= THRESHOLD_RESET;
            max_lag_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            m_freq_reg  <= '0;
            m_found_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sr_reg      <= sr_next;
            thr_reg     <= thr_next;
            max_lag_reg <= max_lag_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
            m_freq_reg  <= m_freq_next;
            m_found_reg <= m_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tau_reg       <= tau_next;
        i_reg         <= i_next;
        acc_reg       <= acc_next;
        sq_reg        <= sq_next;
        running_reg   <= running_next;
        prod_reg      <= prod_next;
        best_reg      <= best_next;
        cur_reg       <= cur_next;
        s2_reg        <= s2_next;
        div_reg       <= div_next;
        dd_reg        <= dd_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        res_freq_reg  <= res_freq_next;
        res_found_reg <= res_found_next;
    end

    `YIN_ASSERT_NOW(a_ready_div_idle, s_tready, !div_stat.busy,
        "input accepted while the divider is busy")
    `YIN_ASSERT_NOW(a_no_dwrite_collect, state_reg == S_COLLECT, !dmem_we,
        "difference memory written while collecting samples")
    `YIN_ASSERT_NEXT(a_last_closes, s_tvalid && s_tready && s_tlast, !s_tready,
        "input still accepted after the window was closed")
    `YIN_ASSERT_NEXT(a_done_pulse, div_stat.done, !div_stat.done,
        "divider done held for more than one cycle")

endmodule

`default_nettype wire

// File: dv/yin_pitch_detector_test.sv
// Self-checking testbench for the YIN pitch detector: directed table, then random windows.
// Depends on yin_pkg and the yin_pitch_detector RTL; no files or arguments are read.
`default_nettype none

module yin_pitch_detector_test;
    import yin_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX     = 2048;
    localparam int LAG_MAX     = 512;
    localparam int RANDOM_GOAL = 800;

    // Kinds of random window content.
    typedef enum int {WIN_PERIODIC, WIN_NOISE, WIN_FLAT} window_kind_t;

    typedef struct packed {
        logic [23:0] freq;
        logic        found;
    } pitch_t;

    // One row of the directed table: either a register write or one sample item.
    typedef struct {
        bit          is_cfg;
        cfg_index_t  reg_index;
        logic [15:0] value;
        bit          lst;
        bit          typed;
        pitch_t      typed_pitch;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [FREQ_W-1:0]   m_tdata;
    logic                m_tuser;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [0:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    yin_pitch_detector DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the block's registers and window store.
    int unsigned       rate_hz;
    int unsigned       thresh_q16;
    int                window_samples [WIN_MAX];
    int unsigned       window_fill;
    longint unsigned   lag_values [LAG_MAX];

    pitch_t            pending_pitches [$];
    int                mismatches;
    int                pitches_checked;
    int                items_sent;
    int                windows_sent;
    bit                sender_busy_mode;
    bit                pending_typed;
    pitch_t            pending_typed_pitch;

    // floor(num * 2^16 / den), the same quotient the block's divider gives: integer part,
    // then sixteen restoring steps, kept to 48 bits.
    function automatic longint unsigned q16_quotient(longint unsigned num,
                                                     longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        for (int k = 0; k < 16; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q & 64'hFFFF_FFFF_FFFF;
    endfunction

    function automatic logic [23:0] clamp_freq(longint unsigned v);
        return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

    // Pitch that the closed window should produce under the current settings.
    function automatic pitch_t estimate_pitch();
        pitch_t          p;
        int unsigned     max_lag;
        longint unsigned running;
        longint unsigned sum;
        longint unsigned base;
        longint          delta;
        longint          s0, s1, s2, dv, num, den;
        int unsigned     best;
        p = '0;
        running = 0;
        max_lag = rate_hz / 100;
        if (max_lag > LAG_MAX)
        begin
            max_lag = LAG_MAX;
        end
        if (max_lag < 2)
        begin
            return p;
        end
        lag_values[0] = 65536;
        for (int unsigned tau = 1; tau < max_lag; tau++)
        begin
            sum = 0;
            for (int unsigned i = 0; i + tau < window_fill; i++)
            begin
                delta = longint'(window_samples[i]) - longint'(window_samples[i + tau]);
                sum += longint'(delta * delta);
            end
            lag_values[tau] = sum & 64'hFFFF_FFFF_FFFF;
        end
        // Cumulative-mean normalization; a zero running sum leaves the lag at zero.
        for (int unsigned tau = 1; tau < max_lag; tau++)
        begin
            running += lag_values[tau];
            if (running > 0)
            begin
                lag_values[tau] = q16_quotient(lag_values[tau] * tau, running);
            end
        end
        for (int unsigned tau = 1; tau < max_lag; tau++)
        begin
            if (lag_values[tau] < thresh_q16)
            begin
                best = tau;
                base = longint'(rate_hz) << 8;
                while (best + 1 < max_lag && lag_values[best + 1] < lag_values[best])
                begin
                    best++;
                end
                p.found = 1'b1;
                if (best < max_lag - 1)
                begin
                    s0 = longint'(lag_values[best - 1]);
                    s1 = longint'(lag_values[best]);
                    s2 = longint'(lag_values[best + 1]);
                    dv = 2 * s1 - s2 - s0;
                    if (dv != 0)
                    begin
                        num = longint'(base) * 2 * dv;
                        den = 2 * dv * longint'(best) + (s2 - s0);
                        // Refined lag of zero saturates high, a negative one clips to zero.
                        if (den == 0)
                        begin
                            p.freq = 24'hFF_FFFF;
                            return p;
                        end
                        if (den < 0)
                        begin
                            den = -den;
                            num = -num;
                        end
                        if (num <= 0)
                        begin
                            p.freq = '0;
                            return p;
                        end
                        p.freq = clamp_freq(longint'(num) / longint'(den));
                        return p;
                    end
                end
                p.freq = clamp_freq(base / best);
                return p;
            end
        end
        return p;
    endfunction

    // Record an accepted sample; on the last one, queue what the block must report.
    task automatic take_sample(logic [15:0] smp, bit lst);
        if (window_fill < WIN_MAX)
        begin
            window_samples[window_fill] = int'($signed(smp));
            window_fill++;
        end
        if (lst)
        begin
            if (pending_typed)
            begin
                pending_pitches.push_back(pending_typed_pitch);
            end
            else
            begin
                pending_pitches.push_back(estimate_pitch());
            end
            window_fill = 0;
            windows_sent++;
        end
    endtask

    // Send one sample item after a random gap; valid stays high if no gap follows.
    task automatic send_sample(logic [15:0] smp, bit lst);
        int gap;
        gap = sender_busy_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        take_sample(smp, lst);
        items_sent++;
    endtask

    task automatic release_stream();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // Register writes happen only with the block idle: no item pending, no result owed.
    task automatic write_register(cfg_index_t idx, logic [15:0] value);
        release_stream();
        wait (pending_pitches.size() == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SAMPLE_RATE)
        begin
            rate_hz = 32'(value);
        end
        else
        begin
            thresh_q16 = 32'(value);
        end
    endtask

    // One window of random content; the period of a periodic window lies in the lag range.
    task automatic send_window(int len, window_kind_t kind);
        int period;
        int amp;
        int level;
        int smp;
        period = $urandom_range(2, rate_hz / 100 > 3 ? rate_hz / 100 - 1 : 2);
        amp    = $urandom_range(1, 32000);
        level  = $urandom_range(0, 65535) - 32768;
        sender_busy_mode = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                WIN_PERIODIC: smp = ((i % period) < period / 2 ? amp : -amp)
                                    + $urandom_range(0, 1000) - 500;
                WIN_NOISE:    smp = $urandom_range(0, 65535) - 32768;
                default:      smp = level;
            endcase
            if (smp > 32767)
            begin
                smp = 32767;
            end
            if (smp < -32768)
            begin
                smp = -32768;
            end
            send_sample(smp[15:0], i == len - 1);
        end
    endtask

    // Directed table. Typed rows carry the answer that can be worked out by hand:
    // silence passes at lag one and parabolic refinement gives two thirds of
    // 256 times the rate, and a zero threshold never passes.
    row_t plan [] = '{
        '{0, CFG_SAMPLE_RATE, 16'h0000, 1, 1, '{24'd8192000, 1'b1}},
        '{0, CFG_SAMPLE_RATE, 16'h0000, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h0000, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h0000, 1, 1, '{24'd8192000, 1'b1}},
        '{0, CFG_SAMPLE_RATE, 16'h7FFF, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h8000, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h7FFF, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h8000, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h7FFF, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h8000, 1, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'hFFFF, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h0001, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'hFFFF, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h0001, 1, 0, '0},
        '{1, CFG_THRESHOLD,   16'd0,    0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h0000, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h0000, 1, 1, '{24'd0, 1'b0}},
        '{1, CFG_THRESHOLD,   16'hFFFF, 0, 0, '0},
        '{1, CFG_SAMPLE_RATE, 16'd8000, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h1234, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'hEDCB, 0, 0, '0},
        '{0, CFG_SAMPLE_RATE, 16'h1234, 1, 0, '0}
    };

    // Result side: random stalls with stretches of none, and the scoreboard check.
    initial
    begin
        bit     no_stall;
        int     stall;
        pitch_t want;
        m_tready = 1'b0;
        no_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                no_stall = !no_stall;
            end
            stall = no_stall ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (pending_pitches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: freq %0d found %0d", m_tdata, m_tuser);
                end
            end
            else
            begin
                want = pending_pitches.pop_front();
                pitches_checked++;
                if (m_tdata !== want.freq || m_tuser !== want.found)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("pitch mismatch: expected freq %0d found %0d, got %0d %0d",
                                 want.freq, want.found, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases over several settings.
    initial
    begin
        int           len;
        window_kind_t kind;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rate_hz     = 48000;
        thresh_q16  = 9830;
        window_fill = 0;
        mismatches  = 0;
        pitches_checked = 0;
        items_sent  = 0;
        windows_sent = 0;
        sender_busy_mode = 1'b0;
        pending_typed = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            if (plan[r].is_cfg)
            begin
                write_register(plan[r].reg_index, plan[r].value);
            end
            else
            begin
                pending_typed       = plan[r].typed;
                pending_typed_pitch = plan[r].typed_pitch;
                send_sample(plan[r].value, plan[r].lst);
                pending_typed = 1'b0;
            end
        end

        // Random phases at low rates keep analysis short; the threshold sweeps its range.
        while (items_sent < RANDOM_GOAL - 80)
        begin
            write_register(CFG_SAMPLE_RATE, 16'($urandom_range(8000, 12000)));
            case ($urandom_range(0, 3))
                0:       write_register(CFG_THRESHOLD, 16'd0);
                1:       write_register(CFG_THRESHOLD, 16'hFFFF);
                default: write_register(CFG_THRESHOLD, 16'($urandom_range(0, 65535)));
            endcase
            repeat ($urandom_range(3, 8))
            begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4)
                                                   : $urandom_range(5, 40);
                kind = window_kind_t'($urandom_range(0, 5) < 4 ? WIN_PERIODIC
                                      : $urandom_range(1, 2));
                if (items_sent < RANDOM_GOAL - 80)
                begin
                    send_window(len, kind);
                end
            end
        end

        // Top of the rate range: a few windows only, since the lag range is widest here.
        write_register(CFG_SAMPLE_RATE, 16'd51199);
        write_register(CFG_THRESHOLD, 16'd20000);
        repeat (3)
        begin
            send_window($urandom_range(8, 40), WIN_PERIODIC);
        end
        release_stream();

        wait (pending_pitches.size() == 0);
        repeat (50) @(posedge clk);
        $display("Covered %0d sample items in %0d windows, %0d pitches checked,",
                 items_sent, windows_sent, pitches_checked);
        $display("over rates 8000 to 51199 Hz and thresholds 0 to 65535.");
        if (mismatches == 0)
        begin
            $display("yin_pitch_detector_test: PASS");
        end
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("yin_pitch_detector_test: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake or a lost result.
    initial
    begin
        #50ms;
        $display("timeout with %0d results outstanding", pending_pitches.size());
        $display("yin_pitch_detector_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/yin_pkg.sv
rtl/yin_div.sv
rtl/yin_pitch_detector.sv
dv/yin_pitch_detector_test.sv
